// ===== hdl/tlt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlt_pkg
// Shared types and constants of the tensor layout transpose address block.
// ----------------------------------------------------------------------------
package tlt_pkg;

  // Width of the dimension registers and of the layout mode register.
  localparam int DIM_W   = 16;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int VALUE_W = 32;
  localparam int DEST_W  = 32;

  // Layout modes. Any other code behaves as NHWC to NCHW.
  localparam logic [MODE_W-1:0] MODE_2D        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NCHW_NHWC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NHWC_NCHW = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_A       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_B       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_H       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_W       = 3'd4;

  // Multiply-add steps per item, minus one.
  localparam logic [1:0] LAST_PHASE_2D = 2'd0;
  localparam logic [1:0] LAST_PHASE_4D = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] layout_mode;
    logic [DIM_W-1:0]  dim_a;
    logic [DIM_W-1:0]  dim_b;
    logic [DIM_W-1:0]  dim_h;
    logic [DIM_W-1:0]  dim_w;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;   // take the input item, snapshot and step the counters
    logic mac;    // one multiply-add step of the address
    logic store;  // move the finished result into the output register
  } cmd_t;

  typedef struct packed {
    logic last_step;  // the current multiply-add step is the final one
  } status_t;

endpackage

// ===== hdl/tlt_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlt_regs
// Configuration registers: layout mode and the four tensor dimensions.
// ----------------------------------------------------------------------------
module tlt_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlt_pkg::DIM_W-1:0]          cfg_data,
  output tlt_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layout_mode <= tlt_pkg::MODE_2D;
      cfg.dim_a       <= tlt_pkg::DIM_W'(1);
      cfg.dim_b       <= tlt_pkg::DIM_W'(1);
      cfg.dim_h       <= tlt_pkg::DIM_W'(1);
      cfg.dim_w       <= tlt_pkg::DIM_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        tlt_pkg::REG_LAYOUT_MODE: cfg.layout_mode <= cfg_data[tlt_pkg::MODE_W-1:0];
        tlt_pkg::REG_DIM_A:       cfg.dim_a       <= cfg_data;
        tlt_pkg::REG_DIM_B:       cfg.dim_b       <= cfg_data;
        tlt_pkg::REG_DIM_H:       cfg.dim_h       <= cfg_data;
        tlt_pkg::REG_DIM_W:       cfg.dim_w       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/tlt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlt_datapath
// Coordinate counters, a shared multiply-add unit for the destination
// address and the output register.
// ----------------------------------------------------------------------------
module tlt_datapath #(
  parameter int DIM_BITS  = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tlt_pkg::cfg_t                 cfg,
  input  tlt_pkg::cmd_t                 cmd,
  output tlt_pkg::status_t              status,
  input  logic [tlt_pkg::VALUE_W-1:0]   in_value,
  output logic [tlt_pkg::DEST_W-1:0]    out_address,
  output logic [tlt_pkg::VALUE_W-1:0]   out_value,
  output logic                          out_last
);

  localparam int CMP_W = (DIM_BITS > tlt_pkg::DIM_W) ? DIM_BITS : tlt_pkg::DIM_W;

  // Live coordinate counters.
  logic [DIM_BITS-1:0] coord_outer, coord_second, coord_third, coord_inner;
  logic [DIM_BITS-1:0] coord_outer_next, coord_second_next;
  logic [DIM_BITS-1:0] coord_third_next, coord_inner_next;
  logic                last_next;

  // Snapshot of the item under work.
  logic [DIM_BITS-1:0]          snap_outer, snap_second, snap_third, snap_inner;
  logic [tlt_pkg::VALUE_W-1:0]  snap_value;
  logic                         snap_last;

  logic [ADDR_BITS-1:0] acc, acc_next, prod;
  logic [1:0]           phase;
  logic [1:0]           last_phase;

  logic [tlt_pkg::DIM_W-1:0] eff_a, eff_b, eff_h, eff_w;
  logic [tlt_pkg::DIM_W-1:0] dim_inner, dim_third, dim_second, mac_dim;
  logic [DIM_BITS-1:0]       mac_coord;
  logic                      mode_2d, mode_nchw;

  // True when the counter has reached the final index of its dimension.
  function automatic logic at_end(input logic [DIM_BITS-1:0] ctr,
                                  input logic [tlt_pkg::DIM_W-1:0] dim);
    logic [CMP_W-1:0] c;
    logic [CMP_W-1:0] d;
    c = CMP_W'(ctr);
    d = CMP_W'(dim) - CMP_W'(1);
    return c >= d;
  endfunction

  assign eff_a = (cfg.dim_a == '0) ? tlt_pkg::DIM_W'(1) : cfg.dim_a;
  assign eff_b = (cfg.dim_b == '0) ? tlt_pkg::DIM_W'(1) : cfg.dim_b;
  assign eff_h = (cfg.dim_h == '0) ? tlt_pkg::DIM_W'(1) : cfg.dim_h;
  assign eff_w = (cfg.dim_w == '0) ? tlt_pkg::DIM_W'(1) : cfg.dim_w;

  assign mode_2d   = (cfg.layout_mode == tlt_pkg::MODE_2D);
  assign mode_nchw = (cfg.layout_mode == tlt_pkg::MODE_NCHW_NHWC);

  always_comb begin
    if (mode_nchw) begin
      dim_inner  = eff_w;
      dim_third  = eff_h;
      dim_second = eff_b;
    end else if (mode_2d) begin
      dim_inner  = eff_b;
      dim_third  = eff_h;
      dim_second = eff_w;
    end else begin
      dim_inner  = eff_b;
      dim_third  = eff_w;
      dim_second = eff_h;
    end
  end

  // Carry chain of the counters, innermost first.
  always_comb begin
    logic c_inner, c_third, c_second, c_outer, c_mid;
    c_inner  = at_end(coord_inner, dim_inner);
    c_third  = 1'b0;
    c_second = 1'b0;
    c_outer  = 1'b0;
    coord_inner_next  = c_inner ? '0 : coord_inner + DIM_BITS'(1);
    coord_third_next  = coord_third;
    coord_second_next = coord_second;
    coord_outer_next  = coord_outer;
    if (mode_2d) begin
      // The middle counters do not exist in the 2D transpose.
      coord_third_next  = '0;
      coord_second_next = '0;
      c_mid = c_inner;
    end else begin
      if (c_inner) begin
        c_third = at_end(coord_third, dim_third);
        coord_third_next = c_third ? '0 : coord_third + DIM_BITS'(1);
      end
      if (c_third) begin
        c_second = at_end(coord_second, dim_second);
        coord_second_next = c_second ? '0 : coord_second + DIM_BITS'(1);
      end
      c_mid = c_second;
    end
    if (c_mid) begin
      c_outer = at_end(coord_outer, eff_a);
      coord_outer_next = c_outer ? '0 : coord_outer + DIM_BITS'(1);
    end
    last_next = c_mid && c_outer;
    if (last_next) begin
      coord_inner_next  = '0;
      coord_third_next  = '0;
      coord_second_next = '0;
      coord_outer_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_outer  <= '0;
      coord_second <= '0;
      coord_third  <= '0;
      coord_inner  <= '0;
    end else if (cmd.load) begin
      coord_outer  <= coord_outer_next;
      coord_second <= coord_second_next;
      coord_third  <= coord_third_next;
      coord_inner  <= coord_inner_next;
    end
  end

  // Operand selection of the multiply-add unit: acc = acc * dim + coord.
  always_comb begin
    mac_dim   = eff_a;
    mac_coord = snap_outer;
    if (mode_2d) begin
      mac_dim   = eff_a;
      mac_coord = snap_outer;
    end else if (mode_nchw) begin
      case (phase)
        2'd0: begin mac_dim = eff_h; mac_coord = snap_third;  end
        2'd1: begin mac_dim = eff_w; mac_coord = snap_inner;  end
        default: begin mac_dim = eff_b; mac_coord = snap_second; end
      endcase
    end else begin
      case (phase)
        2'd0: begin mac_dim = eff_b; mac_coord = snap_inner;  end
        2'd1: begin mac_dim = eff_h; mac_coord = snap_second; end
        default: begin mac_dim = eff_w; mac_coord = snap_third; end
      endcase
    end
  end

  // Products and sums wrap at the address width.
  assign prod     = acc * ADDR_BITS'(mac_dim);
  assign acc_next = prod + ADDR_BITS'(mac_coord);

  assign last_phase       = mode_2d ? tlt_pkg::LAST_PHASE_2D : tlt_pkg::LAST_PHASE_4D;
  assign status.last_step = (phase == last_phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cmd.load) begin
      phase <= '0;
    end else if (cmd.mac) begin
      phase <= phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      snap_outer  <= coord_outer;
      snap_second <= coord_second;
      snap_third  <= coord_third;
      snap_inner  <= coord_inner;
      snap_value  <= in_value;
      snap_last   <= last_next;
      // The 2D address starts from the column; the 4D ones from the batch.
      acc <= mode_2d ? ADDR_BITS'(coord_inner) : ADDR_BITS'(coord_outer);
    end else if (cmd.mac) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      out_address <= tlt_pkg::DEST_W'(acc);
      out_value   <= snap_value;
      out_last    <= snap_last;
    end
  end

endmodule

// ===== hdl/tlt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlt_ctrl
// Sequencer: takes one item, runs the multiply-add steps and hands the
// result to the output register once it is free.
// ----------------------------------------------------------------------------
module tlt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tlt_pkg::status_t  status,
  output tlt_pkg::cmd_t     cmd
);

  tlt_pkg::state_t state, state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      tlt_pkg::S_IDLE:   if (in_valid) state_next = tlt_pkg::S_CALC;
      tlt_pkg::S_CALC:   if (status.last_step) state_next = tlt_pkg::S_FINISH;
      tlt_pkg::S_FINISH: if (out_free) state_next = tlt_pkg::S_IDLE;
      default:           state_next = tlt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.mac   = 1'b0;
    cmd.store = 1'b0;
    case (state)
      tlt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      tlt_pkg::S_CALC:   cmd.mac = 1'b1;
      tlt_pkg::S_FINISH: cmd.store = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.store) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A result never overwrites one that has not been taken.
  a_store_free: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (!out_valid || out_ready))
    else $error("result stored over an untaken result");

  // Commands are mutually exclusive.
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mac, cmd.store}))
    else $error("more than one datapath command at once");

  // At least one multiply-add step separates taking an item and its result.
  a_load_then_mac: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (cmd.mac && !cmd.store))
    else $error("item loaded without a multiply-add step following");

  // Every stored result raises the output valid in the next cycle.
  a_store_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> out_valid)
    else $error("stored result not presented");

endmodule

// ===== hdl/tensor_layout_transpose_addr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_layout_transpose_addr
// Destination address generator for 2D transpose and NCHW/NHWC conversion.
// ----------------------------------------------------------------------------
// Tensor elements arrive on the s_axis channel in source order, one 32-bit
// pattern per item. Each leaves on m_axis unchanged, together with its flat
// index in the destination tensor; tlast marks the final element of the
// tensor, after which the coordinate counters start again from zero.
// The cfg channel writes the layout mode (index 0) and the dimensions
// (indexes 1 to 4); it is always ready. The user must write it only while
// idle; the block does not enforce this. One multiply-add unit builds the
// address step by step: one step in the 2D mode, three in the 4D modes.
// An item is snapshot, the steps run, and the address is stored into the
// output register; a new item is accepted only after that store.
// The result sits in an output register, so the next item is accepted while
// the receiver stalls; that item's result waits in the datapath until the
// output register is taken.
// Reset clears the counters, sets the mode to 2D and every dimension to 1.
// ----------------------------------------------------------------------------
module tensor_layout_transpose_addr #(
  parameter int DIM_BITS  = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tlt_pkg::VALUE_W-1:0]       s_axis_tdata,   // elem_value
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // dest_address [31:0], out_value [63:32]
  output logic [tlt_pkg::DEST_W+tlt_pkg::VALUE_W-1:0] m_axis_tdata,
  output logic                              m_axis_tlast,   // tensor_last
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tlt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlt_pkg::DIM_W-1:0]         cfg_data
);

  tlt_pkg::cfg_t    cfg;
  tlt_pkg::cmd_t    cmd;
  tlt_pkg::status_t status;

  logic [tlt_pkg::DEST_W-1:0]  out_address;
  logic [tlt_pkg::VALUE_W-1:0] out_value;

  tlt_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tlt_datapath #(
    .DIM_BITS  (DIM_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .in_value    (s_axis_tdata),
    .out_address (out_address),
    .out_value   (out_value),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {out_value, out_address};

endmodule
